FILE: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, codes, constants and state type of the pure pursuit
// steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

   // table geometry
   localparam int WP_DEPTH = 1024;
   localparam int WP_AW    = $clog2(WP_DEPTH);
   localparam int CNT_W    = WP_AW + 1;

   // field widths
   localparam int COORD_W   = 32;
   localparam int HEAD_W    = 16;
   localparam int LOOK_W    = 21;
   localparam int GAIN_W    = 16;
   localparam int STEER_W   = 16;
   localparam int SPEED_W   = 19;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 21;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_POSE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT     = 2'd2;

   // register reset values
   localparam logic [LOOK_W-1:0] LOOK_RESET = 21'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   // cordic
   localparam int CORDIC_STEPS = 16;
   localparam logic signed [26:0] CORDIC_K = 27'sd10188014;

   // steering and speed
   localparam int QUOT_BITS = 25;
   localparam logic [QUOT_BITS-1:0] THRESH_5DEG = 25'd5719;
   localparam logic [QUOT_BITS-1:0] THRESH_8DEG = 25'd9151;
   localparam logic [QUOT_BITS-1:0] STEER_LIMIT = 25'd27525;
   localparam logic [SPEED_W-1:0] SPEED_FAST = 19'd294912;
   localparam logic [SPEED_W-1:0] SPEED_MID  = 19'd85197;
   localparam logic [SPEED_W-1:0] SPEED_SLOW = 19'd32768;

   // arctangent of 2^-i, full turn spans 2^32
   function automatic logic [29:0] cordic_atan(input logic [3:0] i);
      logic [29:0] v;
      case (i)
         4'd0:    v = 30'd536870912;
         4'd1:    v = 30'd316933406;
         4'd2:    v = 30'd167458907;
         4'd3:    v = 30'd85004756;
         4'd4:    v = 30'd42667331;
         4'd5:    v = 30'd21354465;
         4'd6:    v = 30'd10679838;
         4'd7:    v = 30'd5340245;
         4'd8:    v = 30'd2670163;
         4'd9:    v = 30'd1335087;
         4'd10:   v = 30'd667544;
         4'd11:   v = 30'd333772;
         4'd12:   v = 30'd166886;
         4'd13:   v = 30'd83443;
         4'd14:   v = 30'd41722;
         4'd15:   v = 30'd20861;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_RD,
      ST_DX,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_SQ0,
      ST_SQ1,
      ST_SQ2,
      ST_SQRT,
      ST_CMP,
      ST_F0,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/pps_if.sv
// ----------------------------------------------------------------------------
// pps channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface pps_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [pps_pkg::WP_AW-1:0]           waypoint_index;
   logic signed [pps_pkg::COORD_W-1:0]  waypoint_x;
   logic signed [pps_pkg::COORD_W-1:0]  waypoint_y;
   logic signed [pps_pkg::COORD_W-1:0]  pose_x;
   logic signed [pps_pkg::COORD_W-1:0]  pose_y;
   logic signed [pps_pkg::HEAD_W-1:0]   pose_heading;

   modport source (output valid, operation, waypoint_index, waypoint_x, waypoint_y,
                   pose_x, pose_y, pose_heading, input ready);
   modport sink   (input valid, operation, waypoint_index, waypoint_x, waypoint_y,
                   pose_x, pose_y, pose_heading, output ready);
endinterface

interface pps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pps_pkg::STEER_W-1:0]  steer_angle;
   logic [pps_pkg::SPEED_W-1:0]         speed;
   logic                                target_found;

   modport source (output valid, steer_angle, speed, target_found, input ready);
   modport sink   (input valid, steer_angle, speed, target_found, output ready);
endinterface

interface pps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pps_pkg::CSR_IDX_W-1:0]       index;
   logic [pps_pkg::CSR_DAT_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Waypoint table in a synchronous memory; each pose item walks the table and
// returns a steering angle and speed for the best lookahead target.
//
//   channel  dir  carries
//   req      in   load waypoint (index, x, y) or pose (x, y, heading)
//   rsp      out  steer_angle, speed, target_found (one per pose)
//   csr      in   register index and data, always ready
//
// A load item is taken only while idle and writes the table directly.
// A pose item runs the cordic, then for each of n table entries one memory
// read, five multiplier passes, three for the squares, and a 32-step bitwise
// square root; a found target may end with the 25-step divider.
// The result waits in an output register; a new item is taken meanwhile.
// Reset clears control state and the registers; the table is not cleared.
// ----------------------------------------------------------------------------
module pure_pursuit_steering (
   input  logic        clock,
   input  logic        reset,
   pps_req_if.sink     req,
   pps_rsp_if.source   rsp,
   pps_csr_if.sink     csr
);
   import pps_pkg::*;

   // saturate to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [39:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 40'sh007FFFFFFF)      r = 32'sh7FFFFFFF;
      else if (v < -40'sh0080000000) r = 32'sh80000000;
      else                           r = v[COORD_W-1:0];
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [LOOK_W-1:0] look_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [CNT_W-1:0]  count_ff;

   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [33:0] ang_ff, ang_in;
   logic signed [26:0] cx_ff, cx_in, cy_ff, cy_in;
   logic               flip_ff, flip_in;
   logic [4:0]         step_ff, step_in;
   logic [CNT_W-1:0]   idx_ff, idx_in, n_ff, n_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [COORD_W-1:0] xc_ff, xc_in, yc_ff, yc_in;
   logic [63:0]        rad_ff, rad_in, root_ff, root_in;
   logic               found_ff, found_in;
   logic [32:0]        berr_ff, berr_in;
   logic signed [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [63:0]        den_ff, den_in, rem_ff, rem_in;
   logic [QUOT_BITS-1:0] quo_ff, quo_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [STEER_W-1:0]  steer_ff, steer_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic                       tf_ff, tf_in;

   logic [63:0]          wp_mem [WP_DEPTH];
   logic [63:0]          mem_rd_ff;
   logic                 mem_we;

   logic signed [33:0]   mul_a, mul_b;
   logic signed [67:0]   mul_p;

   logic req_acc;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_acc   = req.valid && req.ready;
   assign mem_we    = req_acc && (req.operation == OP_LOAD);
   assign csr.ready = 1'b1;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.steer_angle    = steer_ff;
   assign rsp.speed          = speed_ff;
   assign rsp.target_found   = tf_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff  <= LOOK_RESET;
         gain_ff  <= GAIN_RESET;
         count_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_LOOKAHEAD: look_ff  <= csr.data[LOOK_W-1:0];
            CSR_GAIN:      gain_ff  <= csr.data[GAIN_W-1:0];
            CSR_COUNT:     count_ff <= csr.data[CNT_W-1:0];
            default:       ;
         endcase
      end
   end

   // waypoint table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wp_mem[req.waypoint_index] <= {req.waypoint_x, req.waypoint_y};
      end
      mem_rd_ff <= wp_mem[idx_ff[WP_AW-1:0]];
   end

   // shared multiplier
   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[63:0];

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      px_ff <= px_in;   py_ff <= py_in;
      ang_ff <= ang_in; cx_ff <= cx_in; cy_ff <= cy_in; flip_ff <= flip_in;
      step_ff <= step_in; idx_ff <= idx_in; n_ff <= n_in;
      dx_ff <= dx_in;   dy_ff <= dy_in;
      prod_ff <= prod_in; acc_ff <= acc_in;
      xc_ff <= xc_in;   yc_ff <= yc_in;
      rad_ff <= rad_in; root_ff <= root_in;
      berr_ff <= berr_in; bx_ff <= bx_in; by_ff <= by_in;
      den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      steer_ff <= steer_in; speed_ff <= speed_in; tf_ff <= tf_in;
   end

   // sequencer and datapath next values
   always_comb begin
      logic signed [33:0] a0;
      logic signed [26:0] xs, ys, xn, yn;
      logic signed [33:0] atn;
      logic signed [63:0] sum;
      logic [63:0]        bitv, t;
      logic [32:0]        d, err;
      logic               qual;
      logic [32:0]        aby;
      logic [64:0]        r2;
      logic [QUOT_BITS-1:0] mag;

      state_in = state_ff;
      px_in = px_ff; py_in = py_ff;
      ang_in = ang_ff; cx_in = cx_ff; cy_in = cy_ff; flip_in = flip_ff;
      step_in = step_ff; idx_in = idx_ff; n_in = n_ff;
      dx_in = dx_ff; dy_in = dy_ff; acc_in = acc_ff;
      xc_in = xc_ff; yc_in = yc_ff;
      rad_in = rad_ff; root_in = root_ff;
      found_in = found_ff; berr_in = berr_ff; bx_in = bx_ff; by_in = by_ff;
      den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      rsp_valid_in = rsp_valid_ff; steer_in = steer_ff;
      speed_in = speed_ff; tf_in = tf_ff;
      mul_a = {{2{dx_ff[32]}}, dx_ff[31:0]};
      mul_b = {{7{cx_ff[26]}}, cx_ff};

      a0 = {{2{req.pose_heading[HEAD_W-1]}}, req.pose_heading, 16'd0};
      xs = cy_ff >>> step_ff[3:0];
      ys = cx_ff >>> step_ff[3:0];
      atn = {4'd0, cordic_atan(step_ff[3:0])};
      sum = '0;
      bitv = 64'd1 << {step_ff, 1'b0};
      t = root_ff + bitv;
      d = {1'b0, root_ff[31:0]};
      err = (d >= {12'd0, look_ff}) ? d - {12'd0, look_ff} : {12'd0, look_ff} - d;
      qual = ($signed({xc_ff, 1'b0}) > $signed({12'd0, look_ff}));
      aby = by_ff[COORD_W-1] ? 33'(-{by_ff[COORD_W-1], by_ff})
                             : {1'b0, by_ff};
      r2 = {rem_ff, 1'b0};
      mag = found_ff ? quo_ff : '0;
      xn = '0;
      yn = '0;

      // consumer has taken the result
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req.operation == OP_POSE)) begin
               px_in = req.pose_x;
               py_in = req.pose_y;
               cx_in = CORDIC_K;
               cy_in = '0;
               step_in = '0;
               idx_in = '0;
               found_in = 1'b0;
               n_in = (count_ff > CNT_W'(WP_DEPTH)) ? CNT_W'(WP_DEPTH) : count_ff;
               // fold angle into plus or minus a quarter turn
               if (a0 > 34'sd1073741824) begin
                  ang_in = a0 - 34'sd2147483648;
                  flip_in = 1'b1;
               end else if (a0 < -34'sd1073741824) begin
                  ang_in = a0 + 34'sd2147483648;
                  flip_in = 1'b1;
               end else begin
                  ang_in = a0;
                  flip_in = 1'b0;
               end
               state_in = ST_CORDIC;
            end
         end
         // one cordic rotation per cycle
         ST_CORDIC: begin
            if (!ang_ff[33]) begin
               xn = cx_ff - xs; yn = cy_ff + ys; ang_in = ang_ff - atn;
            end else begin
               xn = cx_ff + xs; yn = cy_ff - ys; ang_in = ang_ff + atn;
            end
            step_in = step_ff + 5'd1;
            cx_in = xn;
            cy_in = yn;
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               if (flip_ff) begin
                  cx_in = -xn;
                  cy_in = -yn;
               end
               state_in = (n_ff == '0) ? ST_OUT : ST_RD;
            end
         end
         ST_RD: state_in = ST_DX;
         ST_DX: begin
            dx_in = 33'(signed'(mem_rd_ff[63:32])) - 33'(px_ff);
            dy_in = 33'(signed'(mem_rd_ff[31:0])) - 33'(py_ff);
            state_in = ST_P0;
         end
         // car frame rotation through the shared multiplier
         ST_P0: state_in = ST_P1;
         ST_P1: begin
            mul_a = {dy_ff[32], dy_ff};
            mul_b = {{7{cy_ff[26]}}, cy_ff};
            acc_in = prod_ff;
            state_in = ST_P2;
         end
         ST_P2: begin
            mul_b = {{7{cy_ff[26]}}, cy_ff};
            mul_a = {dx_ff[32], dx_ff};
            sum = acc_ff + prod_ff;
            xc_in = sat32(sum[63:24]);
            state_in = ST_P3;
         end
         ST_P3: begin
            mul_a = {dy_ff[32], dy_ff};
            acc_in = prod_ff;
            state_in = ST_P4;
         end
         ST_P4: begin
            sum = prod_ff - acc_ff;
            yc_in = sat32(sum[63:24]);
            state_in = ST_SQ0;
         end
         ST_SQ0: begin
            mul_a = {{2{xc_ff[31]}}, xc_ff};
            mul_b = {{2{xc_ff[31]}}, xc_ff};
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            mul_a = {{2{yc_ff[31]}}, yc_ff};
            mul_b = {{2{yc_ff[31]}}, yc_ff};
            acc_in = prod_ff;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            rad_in = $unsigned(acc_ff) + $unsigned(prod_ff);
            root_in = '0;
            step_in = 5'd31;
            state_in = ST_SQRT;
         end
         // bitwise square root, one result bit per cycle
         ST_SQRT: begin
            if (rad_ff >= t) begin
               rad_in = rad_ff - t;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            step_in = step_ff - 5'd1;
            if (step_ff == '0) state_in = ST_CMP;
         end
         // keep the first entry with the least distance error
         ST_CMP: begin
            if (qual && (!found_ff || err < berr_ff)) begin
               found_in = 1'b1;
               berr_in = err;
               bx_in = xc_ff;
               by_in = yc_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == n_ff) begin
               state_in = (found_in) ? ST_F0 : ST_OUT;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_F0: begin
            mul_a = {{2{bx_ff[31]}}, bx_ff};
            mul_b = {{2{bx_ff[31]}}, bx_ff};
            state_in = ST_F1;
         end
         ST_F1: begin
            mul_a = {{2{by_ff[31]}}, by_ff};
            mul_b = {{2{by_ff[31]}}, by_ff};
            acc_in = prod_ff;
            state_in = ST_F2;
         end
         ST_F2: begin
            mul_a = {18'd0, gain_ff};
            mul_b = {1'b0, aby};
            den_in = $unsigned(acc_ff) + $unsigned(prod_ff);
            state_in = ST_F3;
         end
         ST_F3: begin
            if ($unsigned(prod_ff) >= den_ff) begin
               quo_in = '1;
               state_in = ST_OUT;
            end else begin
               rem_in = $unsigned(prod_ff);
               quo_in = '0;
               step_in = 5'(QUOT_BITS - 1);
               state_in = ST_DIV;
            end
         end
         // restoring division, one quotient bit per cycle
         ST_DIV: begin
            if (r2 >= {1'b0, den_ff}) begin
               rem_in = 64'(r2 - {1'b0, den_ff});
               quo_in = {quo_ff[QUOT_BITS-2:0], 1'b1};
            end else begin
               rem_in = r2[63:0];
               quo_in = {quo_ff[QUOT_BITS-2:0], 1'b0};
            end
            step_in = step_ff - 5'd1;
            if (step_ff == '0) state_in = ST_OUT;
         end
         // speed from unclamped magnitude, then clamp and sign
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               tf_in = found_ff;
               if (!found_ff)              speed_in = SPEED_SLOW;
               else if (mag < THRESH_5DEG) speed_in = SPEED_FAST;
               else if (mag < THRESH_8DEG) speed_in = SPEED_MID;
               else                        speed_in = SPEED_SLOW;
               if (mag > STEER_LIMIT) mag = STEER_LIMIT;
               steer_in = by_ff[COORD_W-1] && found_ff ? -STEER_W'(mag)
                                                       : STEER_W'(mag);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // no target means a fixed slow, straight result
   a_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.target_found |-> rsp.steer_angle == '0 && rsp.speed == SPEED_SLOW)
      else $error("no-target result not neutral");

   // steering stays inside the clamp
   a_steer_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.steer_angle <= $signed(17'(STEER_LIMIT)))
                 && (rsp.steer_angle >= -$signed(17'(STEER_LIMIT))))
      else $error("steering beyond limit");

   // table walk never passes the entry count
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> idx_ff < n_ff && n_ff <= CNT_W'(WP_DEPTH))
      else $error("walk index out of range");

   // an accepted pose starts the sequencer
   a_pose_starts: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.operation == OP_POSE |=> state_ff == ST_CORDIC)
      else $error("pose item did not start");

endmodule
